// ===== hdl/usb_control_request_handler_top_assert.svh =====
// assertion macros used by the usb control request handler controller
`ifndef USB_CONTROL_REQUEST_HANDLER_TOP_ASSERT_SVH
`define USB_CONTROL_REQUEST_HANDLER_TOP_ASSERT_SVH

// same-cycle implication, checked only out of reset
`define USBCRH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked only out of reset
`define USBCRH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/usbcrh_pkg.sv =====
// types, codes and constants of the usb control request handler
package usbcrh_pkg;

	localparam int DESC_SLOTS = 16;
	localparam int SLOT_W = $clog2(DESC_SLOTS);
	localparam int COUNT_W = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// transaction opcodes
	localparam logic [1:0] OP_BUS_RESET = 2'd0;
	localparam logic [1:0] OP_SETUP     = 2'd1;
	localparam logic [1:0] OP_STATUS    = 2'd2;
	localparam logic [1:0] OP_LOAD      = 2'd3;

	// standard request codes
	localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
	localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
	localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

	// bmRequestType values
	localparam logic [7:0] RT_DEV_OUT = 8'h00;
	localparam logic [7:0] RT_IF_OUT  = 8'h01;
	localparam logic [7:0] RT_DEV_IN  = 8'h80;
	localparam logic [7:0] RT_IF_IN   = 8'h81;
	localparam logic [7:0] RT_EP_IN   = 8'h82;

	localparam logic [15:0] MAX_ADDRESS = 16'd127;

	// configuration register indexes
	localparam logic REG_DESC_COUNT = 1'b0;
	localparam logic REG_MAX_CONFIG = 1'b1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] value;
		logic [15:0] index;
		logic [15:0] length;
		logic [3:0]  table_slot;
	} in_item_t;

	typedef struct packed {
		logic        stall_res;
		logic [15:0] reply_length;
		logic [7:0]  reply_byte;
		logic        descriptor_hit;
		logic [3:0]  descriptor_slot;
		logic        address_apply;
		logic [6:0]  device_address;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic advance;
		logic fin_decode;
		logic fin_hit;
		logic fin_miss;
	} cmd_t;

	typedef struct packed {
		logic search_req;
		logic match;
		logic last;
	} sts_t;

endpackage

// ===== hdl/usbcrh_ctrl.sv =====
// controller state machine: capture, decode and descriptor search sequencing
`include "usb_control_request_handler_top_assert.svh"

module usbcrh_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  usbcrh_pkg::sts_t   sts,
	output usbcrh_pkg::cmd_t   cmd
);
	import usbcrh_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECODE = 2'd1;
	localparam logic [1:0] S_SEARCH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.search_req) begin
					state_d = S_SEARCH;
				end else begin
					cmd.fin_decode = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SEARCH: begin
				if (sts.match) begin
					cmd.fin_hit = 1'b1;
					state_d = S_IDLE;
				end else if (sts.last) begin
					cmd.fin_miss = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`USBCRH_ASSERT_NXT(a_capture_decode, cmd.capture, state_q == S_DECODE,
		"capture not followed by decode")
	`USBCRH_ASSERT_IMP(a_search_finish, cmd.fin_hit || cmd.fin_miss, state_q == S_SEARCH,
		"search result outside search")
	`USBCRH_ASSERT_IMP(a_search_entry, state_q == S_SEARCH,
		$past(state_q) == S_DECODE || $past(state_q) == S_SEARCH,
		"search entered without decode")
	`USBCRH_ASSERT_NXT(a_decode_exit, state_q == S_DECODE,
		state_q == S_IDLE || state_q == S_SEARCH,
		"decode did not finish or search")

endmodule

// ===== hdl/usbcrh_dp.sv =====
// datapath: request register, device state, descriptor table and result register
module usbcrh_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  usbcrh_pkg::in_item_t  req,
	input  logic [4:0]            desc_count,
	input  logic [7:0]            max_config,
	input  usbcrh_pkg::cmd_t      cmd,
	output usbcrh_pkg::sts_t      sts,
	output logic                  done,
	output usbcrh_pkg::out_item_t rsp
);
	import usbcrh_pkg::*;

	in_item_t  req_q;
	out_item_t rsp_q;
	out_item_t rsp_d;
	logic      done_q;

	logic [7:0] cur_cfg_q;
	logic       pend_q;
	logic [6:0] pend_addr_q;

	logic [31:0]       mem [DESC_SLOTS];
	logic [31:0]       rdata_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] rd_addr;
	logic [COUNT_W-1:0] slot_n;
	logic [COUNT_W-1:0] next_pos;

	logic        std_req;
	logic        dec_ok;
	logic [15:0] dec_len;
	logic [7:0]  dec_byte;
	logic        set_addr;
	logic        set_cfg;
	logic [15:0] hit_len;
	logic        finish;

	assign finish = cmd.fin_decode || cmd.fin_hit || cmd.fin_miss;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	// searched entries: count saturates at the table depth
	assign slot_n = (desc_count > COUNT_W'(DESC_SLOTS)) ? COUNT_W'(DESC_SLOTS) : desc_count;
	assign next_pos = COUNT_W'(slot_q) + COUNT_W'(1);
	assign std_req = (req_q.request_type[6:5] == 2'b00);

	// read address runs one ahead so each search cycle sees its own entry
	assign rd_addr = cmd.advance ? (slot_q + SLOT_W'(1)) : slot_q;

	always_ff @(posedge clk) begin
		if (cmd.fin_decode && req_q.opcode == OP_LOAD) begin
			mem[req_q.table_slot] <= {req_q.value, req_q.length};
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (cmd.capture) begin
			slot_q <= '0;
		end else if (cmd.advance) begin
			slot_q <= slot_q + SLOT_W'(1);
		end
	end

	assign sts.search_req = (req_q.opcode == OP_SETUP) && std_req
		&& (req_q.request_code == REQ_GET_DESCRIPTOR)
		&& (req_q.request_type == RT_DEV_IN) && (slot_n != '0);
	assign sts.match = (rdata_q[31:16] == req_q.value);
	assign sts.last = (next_pos >= slot_n);

	assign hit_len = (req_q.length < rdata_q[15:0]) ? req_q.length : rdata_q[15:0];

	always_comb begin
		dec_ok = 1'b0;
		dec_len = '0;
		dec_byte = '0;
		set_addr = 1'b0;
		set_cfg = 1'b0;
		case (req_q.request_code)
			REQ_GET_STATUS: begin
				dec_ok = (req_q.value == '0) && (req_q.length == 16'd2)
					&& (req_q.request_type == RT_DEV_IN || req_q.request_type == RT_IF_IN
					|| req_q.request_type == RT_EP_IN);
				dec_len = 16'd2;
			end
			REQ_SET_ADDRESS: begin
				dec_ok = (req_q.request_type == RT_DEV_OUT) && (req_q.index == '0)
					&& (req_q.length == '0) && (req_q.value <= MAX_ADDRESS);
				set_addr = dec_ok;
			end
			REQ_GET_CONFIGURATION: begin
				dec_ok = (req_q.request_type == RT_DEV_IN) && (req_q.value == '0)
					&& (req_q.index == '0) && (req_q.length == 16'd1);
				dec_len = 16'd1;
				dec_byte = cur_cfg_q;
			end
			REQ_SET_CONFIGURATION: begin
				// same value is accepted without the range check
				if ((req_q.request_type == RT_DEV_OUT) && (req_q.index == '0)
					&& (req_q.length == '0)) begin
					if (req_q.value == {8'd0, cur_cfg_q}) begin
						dec_ok = 1'b1;
					end else if (req_q.value <= {8'd0, max_config}) begin
						dec_ok = 1'b1;
						set_cfg = 1'b1;
					end
				end
			end
			REQ_GET_INTERFACE: begin
				dec_ok = (req_q.request_type == RT_IF_IN) && (req_q.value == '0)
					&& (req_q.length == 16'd1);
				dec_len = 16'd1;
			end
			REQ_SET_INTERFACE: begin
				dec_ok = (req_q.request_type == RT_IF_OUT) && (req_q.length == '0)
					&& (req_q.value == '0);
			end
			default: begin
				dec_ok = 1'b0;
			end
		endcase
		if (!std_req) begin
			dec_ok = 1'b0;
			set_addr = 1'b0;
			set_cfg = 1'b0;
		end
		if (!dec_ok) begin
			dec_len = '0;
			dec_byte = '0;
		end
	end

	always_comb begin
		rsp_d = '0;
		if (cmd.fin_hit) begin
			rsp_d.reply_length = hit_len;
			rsp_d.descriptor_hit = 1'b1;
			rsp_d.descriptor_slot = slot_q;
		end else if (cmd.fin_miss) begin
			rsp_d.stall_res = 1'b1;
		end else begin
			case (req_q.opcode)
				OP_SETUP: begin
					rsp_d.stall_res = !dec_ok;
					rsp_d.reply_length = dec_len;
					rsp_d.reply_byte = dec_byte;
				end
				OP_STATUS: begin
					rsp_d.address_apply = pend_q;
					rsp_d.device_address = pend_q ? pend_addr_q : 7'd0;
				end
				default: begin
					rsp_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cfg_q <= '0;
			pend_q <= 1'b0;
			pend_addr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
			if (cmd.fin_hit || cmd.fin_miss) begin
				pend_q <= 1'b0;
			end else if (cmd.fin_decode) begin
				case (req_q.opcode)
					OP_BUS_RESET: begin
						cur_cfg_q <= '0;
						pend_q <= 1'b0;
						pend_addr_q <= '0;
					end
					OP_SETUP: begin
						// any setup transaction drops a pending address
						pend_q <= set_addr;
						if (set_addr) begin
							pend_addr_q <= req_q.value[6:0];
						end
						if (set_cfg) begin
							cur_cfg_q <= req_q.value[7:0];
						end
					end
					OP_STATUS: begin
						pend_q <= 1'b0;
					end
					default: begin
						pend_q <= pend_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp = rsp_q;

endmodule

// ===== hdl/usb_control_request_handler_top.sv =====
// usb endpoint-0 standard request handler: top level with register port
// a request is captured, then decoded, then its result and done strobe are registered; a descriptor
//   lookup searches the table in between, one slot per cycle through a single read port
// a new transaction is taken only while idle, once the previous one has finished
// reset: arst_n clears state, configuration and address; the table is not cleared
// the receiver cannot stall: done is high for a single cycle per result
module usb_control_request_handler_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  usbcrh_pkg::in_item_t              req,
	output logic                              done,
	output usbcrh_pkg::out_item_t             rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [usbcrh_pkg::PADDR_W-1:0]    paddr,
	input  logic [usbcrh_pkg::PDATA_W-1:0]    pwdata,
	output logic [usbcrh_pkg::PDATA_W-1:0]    prdata,
	output logic                              pready
);
	import usbcrh_pkg::*;

	logic [COUNT_W-1:0] desc_count_q;
	logic [7:0]         max_config_q;
	logic               reg_wr;
	cmd_t               cmd;
	sts_t               sts;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_count_q <= '0;
			max_config_q <= 8'd1;
		end else if (reg_wr) begin
			if (paddr[2] == REG_DESC_COUNT) begin
				desc_count_q <= pwdata[COUNT_W-1:0];
			end else begin
				max_config_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_MAX_CONFIG) ? {24'd0, max_config_q}
		: {{(PDATA_W-COUNT_W){1'b0}}, desc_count_q};

	usbcrh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	usbcrh_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.desc_count (desc_count_q),
		.max_config (max_config_q),
		.cmd        (cmd),
		.sts        (sts),
		.done       (done),
		.rsp        (rsp)
	);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench of the usb control request handler: directed rows, then random phases checked against a local model
module testbench;
	import usbcrh_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 100;
	localparam int DRAIN_CYCLES = 24;

	// request codes and request types the block has to reject
	localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE    = 8'd3;
	localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'd7;
	localparam logic [7:0] REQ_SYNCH_FRAME    = 8'd12;
	localparam logic [7:0] RT_VENDOR_DEV_IN   = 8'hC0;
	localparam logic [7:0] RT_OTHER_IN        = 8'h83;

	typedef struct {
		in_item_t  ev;
		bit        typed;
		out_item_t want;
		int        new_count;
	} step_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	in_item_t            req;
	logic                done;
	out_item_t           rsp;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// device state tracked alongside the block
	logic [7:0]            cur_config;
	logic                  addr_pending;
	logic [6:0]            pending_addr;
	logic [15:0]           desc_id [DESC_SLOTS];
	logic [15:0]           desc_len [DESC_SLOTS];
	logic [DESC_SLOTS-1:0] desc_loaded;
	logic [COUNT_W-1:0]    desc_count;
	logic [7:0]            max_config;

	logic [7:0] std_codes [7] = '{REQ_GET_STATUS, REQ_SET_ADDRESS, REQ_GET_DESCRIPTOR,
		REQ_GET_CONFIGURATION, REQ_SET_CONFIGURATION, REQ_GET_INTERFACE, REQ_SET_INTERFACE};

	out_item_t replies_due [$];
	step_t     directed [$];
	int        mismatches;
	int        cycles;
	bit        idle_ok;

	usb_control_request_handler_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int search_depth();
		return (desc_count > DESC_SLOTS) ? DESC_SLOTS : int'(desc_count);
	endfunction

	function automatic int loaded_prefix();
		int n;
		n = 0;
		while (n < DESC_SLOTS && desc_loaded[n])
			n++;
		return n;
	endfunction

	function automatic bit decode_setup(input in_item_t ev, inout out_item_t r);
		int i;
		int n;
		n = search_depth();
		if (ev.request_type[6:5] != 2'b00)
			return 1'b0;
		case (ev.request_code)
			REQ_GET_STATUS: begin
				if (ev.value != 16'd0 || ev.length != 16'd2)
					return 1'b0;
				if (!(ev.request_type inside {RT_DEV_IN, RT_IF_IN, RT_EP_IN}))
					return 1'b0;
				r.reply_length = 16'd2;
				return 1'b1;
			end
			REQ_SET_ADDRESS: begin
				if (ev.request_type != RT_DEV_OUT || ev.index != 16'd0 || ev.length != 16'd0 ||
					ev.value > MAX_ADDRESS)
					return 1'b0;
				addr_pending = 1'b1;
				pending_addr = ev.value[6:0];
				return 1'b1;
			end
			REQ_GET_DESCRIPTOR: begin
				if (ev.request_type != RT_DEV_IN)
					return 1'b0;
				for (i = 0; i < n; i++) begin
					if (desc_id[i] == ev.value) begin
						r.reply_length = (ev.length < desc_len[i]) ? ev.length : desc_len[i];
						r.descriptor_hit = 1'b1;
						r.descriptor_slot = SLOT_W'(i);
						return 1'b1;
					end
				end
				return 1'b0;
			end
			REQ_GET_CONFIGURATION: begin
				if (ev.request_type != RT_DEV_IN || ev.value != 16'd0 || ev.index != 16'd0 ||
					ev.length != 16'd1)
					return 1'b0;
				r.reply_length = 16'd1;
				r.reply_byte = cur_config;
				return 1'b1;
			end
			REQ_SET_CONFIGURATION: begin
				if (ev.request_type != RT_DEV_OUT || ev.index != 16'd0 || ev.length != 16'd0)
					return 1'b0;
				// the current value passes even above the limit
				if (ev.value == {8'd0, cur_config})
					return 1'b1;
				if (ev.value > {8'd0, max_config})
					return 1'b0;
				cur_config = ev.value[7:0];
				return 1'b1;
			end
			REQ_GET_INTERFACE: begin
				if (ev.request_type != RT_IF_IN || ev.value != 16'd0 || ev.length != 16'd1)
					return 1'b0;
				r.reply_length = 16'd1;
				return 1'b1;
			end
			REQ_SET_INTERFACE: begin
				return ev.request_type == RT_IF_OUT && ev.length == 16'd0 && ev.value == 16'd0;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// advances the tracked state by one transaction and returns its reply
	function automatic out_item_t handle_event(input in_item_t ev);
		out_item_t r;
		r = '0;
		case (ev.opcode)
			OP_BUS_RESET: begin
				cur_config = 8'd0;
				addr_pending = 1'b0;
				pending_addr = 7'd0;
			end
			OP_SETUP: begin
				addr_pending = 1'b0;
				if (!decode_setup(ev, r)) begin
					r = '0;
					r.stall_res = 1'b1;
				end
			end
			OP_STATUS: begin
				if (addr_pending) begin
					r.address_apply = 1'b1;
					r.device_address = pending_addr;
					addr_pending = 1'b0;
				end
			end
			default: begin
				desc_id[ev.table_slot] = ev.value;
				desc_len[ev.table_slot] = ev.length;
				desc_loaded[ev.table_slot] = 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic in_item_t setup_pkt(input logic [7:0] rt, input logic [7:0] code,
		input logic [15:0] val, input logic [15:0] idx, input logic [15:0] len);
		in_item_t ev;
		ev = '0;
		ev.opcode = OP_SETUP;
		ev.request_type = rt;
		ev.request_code = code;
		ev.value = val;
		ev.index = idx;
		ev.length = len;
		return ev;
	endfunction

	function automatic in_item_t plain_op(input logic [1:0] op);
		in_item_t ev;
		ev = '0;
		ev.opcode = op;
		return ev;
	endfunction

	function automatic in_item_t load_entry(input logic [3:0] slot, input logic [15:0] id,
		input logic [15:0] len);
		in_item_t ev;
		ev = '0;
		ev.opcode = OP_LOAD;
		ev.table_slot = slot;
		ev.value = id;
		ev.length = len;
		return ev;
	endfunction

	function automatic out_item_t reply(input logic [15:0] len, input logic [7:0] first);
		out_item_t r;
		r = '0;
		r.reply_length = len;
		r.reply_byte = first;
		return r;
	endfunction

	function automatic out_item_t stalled();
		out_item_t r;
		r = '0;
		r.stall_res = 1'b1;
		return r;
	endfunction

	function automatic out_item_t applied(input logic [6:0] addr);
		out_item_t r;
		r = '0;
		r.address_apply = 1'b1;
		r.device_address = addr;
		return r;
	endfunction

	function automatic step_t mk_row(input in_item_t ev, input bit typed, input out_item_t want,
		input int new_count);
		step_t s;
		s.ev = ev;
		s.typed = typed;
		s.want = want;
		s.new_count = new_count;
		return s;
	endfunction

	function automatic logic [15:0] pick_id();
		if ($urandom_range(0, 1) == 0)
			return {8'($urandom_range(1, 3)), 8'($urandom_range(0, 2))};
		return 16'($urandom);
	endfunction

	// random resets, status stages, table loads and standard requests, some noise and broken ones
	function automatic in_item_t random_event();
		in_item_t ev;
		int pick;
		int pre;
		int n;
		ev.opcode = 2'($urandom_range(0, 3));
		ev.request_type = 8'($urandom);
		ev.request_code = 8'($urandom);
		ev.value = 16'($urandom);
		ev.index = 16'($urandom);
		ev.length = 16'($urandom);
		ev.table_slot = 4'($urandom);
		pick = $urandom_range(0, 99);
		if (addr_pending && pick < 70) begin
			ev.opcode = OP_STATUS;
		end else if (pick < 10) begin
			// full noise
		end else if (pick < 15) begin
			ev.opcode = OP_BUS_RESET;
		end else if (pick < 27) begin
			ev.opcode = OP_STATUS;
		end else if (pick < 42) begin
			ev.opcode = OP_LOAD;
			pre = loaded_prefix();
			if (pre < DESC_SLOTS && $urandom_range(0, 99) < 70)
				ev.table_slot = SLOT_W'(pre);
			ev.value = pick_id();
			if ($urandom_range(0, 1) == 0)
				ev.length = 16'($urandom_range(0, 40));
		end else begin
			ev.opcode = OP_SETUP;
			ev.request_code = std_codes[$urandom_range(0, 6)];
			case (ev.request_code)
				REQ_GET_STATUS: begin
					ev.request_type = ($urandom_range(0, 2) == 0) ? RT_DEV_IN :
						($urandom_range(0, 1) == 0) ? RT_IF_IN : RT_EP_IN;
					ev.value = 16'd0;
					ev.length = 16'd2;
				end
				REQ_SET_ADDRESS: begin
					ev.request_type = RT_DEV_OUT;
					ev.value = 16'($urandom_range(0, 127));
					ev.index = 16'd0;
					ev.length = 16'd0;
				end
				REQ_GET_DESCRIPTOR: begin
					ev.request_type = RT_DEV_IN;
					n = search_depth();
					if (n != 0 && $urandom_range(0, 3) != 0)
						ev.value = desc_id[$urandom_range(0, n - 1)];
					else
						ev.value = pick_id();
					if ($urandom_range(0, 1) == 0)
						ev.length = 16'($urandom_range(0, 64));
				end
				REQ_GET_CONFIGURATION: begin
					ev.request_type = RT_DEV_IN;
					ev.value = 16'd0;
					ev.index = 16'd0;
					ev.length = 16'd1;
				end
				REQ_SET_CONFIGURATION: begin
					ev.request_type = RT_DEV_OUT;
					ev.index = 16'd0;
					ev.length = 16'd0;
					case ($urandom_range(0, 3))
						0: ev.value = {8'd0, cur_config};
						1: ev.value = 16'($urandom_range(0, max_config));
						2: ev.value = 16'($urandom_range(0, 255));
						default: ev.value = 16'($urandom_range(256, 65535));
					endcase
				end
				REQ_GET_INTERFACE: begin
					ev.request_type = RT_IF_IN;
					ev.value = 16'd0;
					ev.length = 16'd1;
				end
				default: begin
					ev.request_type = RT_IF_OUT;
					ev.value = 16'd0;
					ev.length = 16'd0;
				end
			endcase
			// break one field now and then
			if ($urandom_range(0, 99) < 12) begin
				case ($urandom_range(0, 3))
					0: ev.request_type[$urandom_range(0, 7)] ^= 1'b1;
					1: ev.value[$urandom_range(0, 15)] ^= 1'b1;
					2: ev.index[$urandom_range(0, 15)] ^= 1'b1;
					default: ev.length[$urandom_range(0, 15)] ^= 1'b1;
				endcase
			end
		end
		return ev;
	endfunction

	// write a register, read it back, then track it
	task automatic set_register(input logic reg_idx, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({reg_idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== data) begin
			$display("%0t: register %0d expected %0h, got %0h", $time, reg_idx, data, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		if (reg_idx == REG_DESC_COUNT)
			desc_count = data[COUNT_W-1:0];
		else
			max_config = data[7:0];
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (replies_due.size() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic issue(input in_item_t ev, input bit typed, input out_item_t want);
		out_item_t predicted;
		if (idle_ok && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start <= 1'b1;
		req <= ev;
		do
			@(posedge clk);
		while (busy);
		predicted = handle_event(ev);
		replies_due.push_back(typed ? want : predicted);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t head;
		if (arst_n && done === 1'b1) begin
			if (replies_due.size() == 0) begin
				$display("%0t: result with none expected, got %p", $time, rsp);
				mismatches++;
			end else begin
				head = replies_due.pop_front();
				check_field("stall_res", 16'(head.stall_res), 16'(rsp.stall_res));
				check_field("reply_length", head.reply_length, rsp.reply_length);
				check_field("reply_byte", 16'(head.reply_byte), 16'(rsp.reply_byte));
				check_field("descriptor_hit", 16'(head.descriptor_hit),
					16'(rsp.descriptor_hit));
				check_field("descriptor_slot", 16'(head.descriptor_slot),
					16'(rsp.descriptor_slot));
				check_field("address_apply", 16'(head.address_apply),
					16'(rsp.address_apply));
				check_field("device_address", 16'(head.device_address),
					16'(rsp.device_address));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		int phase;
		int cnt;
		int mx;
		int pre;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		mismatches = 0;
		idle_ok = 1'b1;
		cur_config = 8'd0;
		addr_pending = 1'b0;
		pending_addr = 7'd0;
		desc_loaded = '0;
		desc_count = '0;
		max_config = 8'd1;

		directed.push_back(mk_row(plain_op(OP_STATUS), 1, '0, -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_IN, REQ_GET_CONFIGURATION, 0, 0, 1), 1,
			reply(1, 0), -1));
		directed.push_back(mk_row(setup_pkt(RT_EP_IN, REQ_GET_STATUS, 0, 16'hFFFF, 2), 1,
			reply(2, 0), -1));
		directed.push_back(mk_row(setup_pkt(RT_OTHER_IN, REQ_GET_STATUS, 0, 0, 2), 1,
			stalled(), -1));
		directed.push_back(mk_row(setup_pkt(RT_VENDOR_DEV_IN, REQ_GET_STATUS, 0, 0, 2), 1,
			stalled(), -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_CLEAR_FEATURE, 1, 0, 0), 1,
			stalled(), -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_SET_FEATURE, 1, 0, 0), 1,
			stalled(), -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_SET_DESCRIPTOR, 16'h0100, 0, 18), 1,
			stalled(), -1));
		directed.push_back(mk_row(setup_pkt(RT_EP_IN, REQ_SYNCH_FRAME, 0, 1, 2), 1,
			stalled(), -1));
		// address applied by the status stage
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_SET_ADDRESS, 127, 0, 0), 1, '0, -1));
		directed.push_back(mk_row(plain_op(OP_STATUS), 1, applied(127), -1));
		// a later setup packet drops the pending address
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_SET_ADDRESS, 5, 0, 0), 1, '0, -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_IN, REQ_GET_STATUS, 0, 0, 2), 1,
			reply(2, 0), -1));
		directed.push_back(mk_row(plain_op(OP_STATUS), 1, '0, -1));
		// bus reset drops it too
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_SET_ADDRESS, 16'h33, 0, 0), 1, '0, -1));
		directed.push_back(mk_row(plain_op(OP_BUS_RESET), 1, '0, -1));
		directed.push_back(mk_row(plain_op(OP_STATUS), 1, '0, -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_SET_CONFIGURATION, 1, 0, 0), 1,
			'0, -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_IN, REQ_GET_CONFIGURATION, 0, 0, 1), 0,
			'0, -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_SET_CONFIGURATION, 2, 0, 0), 1,
			stalled(), -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_SET_CONFIGURATION, 1, 0, 0), 1,
			'0, -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_OUT, REQ_SET_CONFIGURATION, 16'hFFFF, 0, 0), 1,
			stalled(), -1));
		directed.push_back(mk_row(setup_pkt(RT_IF_IN, REQ_GET_INTERFACE, 0, 0, 1), 1,
			reply(1, 0), -1));
		directed.push_back(mk_row(load_entry(0, 16'h0100, 18), 1, '0, -1));
		directed.push_back(mk_row(load_entry(1, 16'h0200, 16'hFFFF), 1, '0, -1));
		directed.push_back(mk_row(load_entry(15, 16'hFFFF, 0), 1, '0, -1));
		// empty search range
		directed.push_back(mk_row(setup_pkt(RT_DEV_IN, REQ_GET_DESCRIPTOR, 16'h0100, 0, 64), 1,
			stalled(), -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_IN, REQ_GET_DESCRIPTOR, 16'h0100, 0, 16'hFFFF),
			0, '0, 2));
		directed.push_back(mk_row(setup_pkt(RT_DEV_IN, REQ_GET_DESCRIPTOR, 16'h0200, 0, 0), 0,
			'0, -1));
		directed.push_back(mk_row(setup_pkt(RT_DEV_IN, REQ_GET_DESCRIPTOR, 16'h0300, 0, 64), 1,
			stalled(), -1));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].new_count >= 0) begin
				wait_idle();
				set_register(REG_DESC_COUNT, directed[i].new_count);
			end
			issue(directed[i].ev, directed[i].typed, directed[i].want);
		end

		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			// the search range never reaches a slot that was not loaded
			pre = loaded_prefix();
			case (phase)
				0: begin
					cnt = 0;
					mx = 0;
				end
				1: begin
					cnt = $urandom_range(0, pre);
					mx = 255;
				end
				2: begin
					cnt = pre;
					mx = $urandom_range(0, 255);
				end
				3: begin
					cnt = pre;
					mx = 1;
				end
				4: begin
					cnt = $urandom_range(0, pre);
					mx = $urandom_range(0, 255);
				end
				default: begin
					cnt = pre;
					mx = 255;
				end
			endcase
			set_register(REG_DESC_COUNT, cnt);
			set_register(REG_MAX_CONFIG, mx);
			idle_ok = (phase != 3);
			repeat (PHASE_ITEMS) issue(random_event(), 1'b0, '0);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
